FILE: hw/rtl/lrm_pkg.sv
// Shared types, constants and color helpers of the LED layer mix engine.
package lrm_pkg;

    // Ring geometry
    localparam int LAYERS    = 3;
    localparam int RING      = 64;
    localparam int LYR_DEPTH = LAYERS * RING;
    localparam int LYR_AW    = 8;

    // Configuration port
    localparam int APB_AW = 5;

    localparam logic [2:0] REG_L1_PERIOD = 3'd0;
    localparam logic [2:0] REG_L2_PERIOD = 3'd1;
    localparam logic [2:0] REG_L3_PERIOD = 3'd2;
    localparam logic [2:0] REG_DIR_MASK  = 3'd3;
    localparam logic [2:0] REG_FL_PERIOD = 3'd4;
    localparam logic [2:0] REG_FL_ENABLE = 3'd5;

    localparam logic [15:0] RST_L1_PERIOD = 16'd57;
    localparam logic [15:0] RST_L2_PERIOD = 16'd7;
    localparam logic [15:0] RST_L3_PERIOD = 16'd29;
    localparam logic [2:0]  RST_DIR_MASK  = 3'd4;
    localparam logic [15:0] RST_FL_PERIOD = 16'd9997;
    localparam logic        RST_FL_ENABLE = 1'b1;

    // Flash windows, exclusive bounds
    localparam logic [15:0] WIN1_LO = 16'd80;
    localparam logic [15:0] WIN1_HI = 16'd100;
    localparam logic [15:0] WIN2_LO = 16'd130;
    localparam logic [15:0] WIN2_HI = 16'd150;

    localparam logic [15:0] WHITE_565 = 16'hFFFF;

    typedef struct packed {
        logic [LAYERS-1:0][15:0] layer_period;
        logic [2:0]              direction_mask;
        logic [15:0]             flash_period;
        logic                    flash_enable;
    } cfg_t;

    // RGB565 to GRB888, fields padded with low zeros
    function automatic logic [23:0] expand_grb(input logic [15:0] c);
        return {c[10:5], 2'b00, c[15:11], 3'b000, c[4:0], 3'b000};
    endfunction

    // Per-channel saturating add of two RGB565 colors
    function automatic logic [15:0] sat_add565(input logic [15:0] x, input logic [15:0] y);
        logic [5:0] r;
        logic [6:0] g;
        logic [5:0] b;
        r = {1'b0, x[15:11]} + {1'b0, y[15:11]};
        g = {1'b0, x[10:5]} + {1'b0, y[10:5]};
        b = {1'b0, x[4:0]} + {1'b0, y[4:0]};
        return {(r[5] ? 5'h1F : r[4:0]), (g[6] ? 6'h3F : g[5:0]), (b[5] ? 5'h1F : b[4:0])};
    endfunction

endpackage

FILE: hw/rtl/lrm_cfg_regs.sv
// APB-style configuration register file of the LED layer mix engine.
module lrm_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output lrm_pkg::cfg_t              cfg
);
    import lrm_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.layer_period[0] <= RST_L1_PERIOD;
            cfg_reg.layer_period[1] <= RST_L2_PERIOD;
            cfg_reg.layer_period[2] <= RST_L3_PERIOD;
            cfg_reg.direction_mask  <= RST_DIR_MASK;
            cfg_reg.flash_period    <= RST_FL_PERIOD;
            cfg_reg.flash_enable    <= RST_FL_ENABLE;
        end else if (wr_en) begin
            case (reg_sel)
                REG_L1_PERIOD: cfg_reg.layer_period[0] <= pwdata[15:0];
                REG_L2_PERIOD: cfg_reg.layer_period[1] <= pwdata[15:0];
                REG_L3_PERIOD: cfg_reg.layer_period[2] <= pwdata[15:0];
                REG_DIR_MASK:  cfg_reg.direction_mask  <= pwdata[2:0];
                REG_FL_PERIOD: cfg_reg.flash_period    <= pwdata[15:0];
                REG_FL_ENABLE: cfg_reg.flash_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_sel)
            REG_L1_PERIOD: prdata = {16'd0, cfg_reg.layer_period[0]};
            REG_L2_PERIOD: prdata = {16'd0, cfg_reg.layer_period[1]};
            REG_L3_PERIOD: prdata = {16'd0, cfg_reg.layer_period[2]};
            REG_DIR_MASK:  prdata = {29'd0, cfg_reg.direction_mask};
            REG_FL_PERIOD: prdata = {16'd0, cfg_reg.flash_period};
            REG_FL_ENABLE: prdata = {31'd0, cfg_reg.flash_enable};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

FILE: hw/rtl/led_layer_rotate_mix_engine.sv
// Top level of the LED layer mix engine: layer rings, display buffer and pixel stream.
//
// Usage
//   Input channel (s_*): op 0 loads one RGB565 color into a layer ring at a strip
//   position and gives no output. op 1 is a frame tick. A tick streams NUM_LEDS
//   pixels on the m_* channel as GRB888 words in strip order, last set on the
//   final one, white during the flash windows. On acceptance it applies the layer
//   rotations; while streaming it writes back the new display buffer, which the
//   next tick shows.
//   Rotation is held as a per-layer ring offset, so no layer data is moved.
//   Each pixel needs three layer reads through the two read ports of the layer
//   RAM, taken in the RDA and RDB states.
//   Each pixel is emitted into the output register after its RDB read, at the next RDA step or in FIN.
//   Backpressure: while m_ready is low with a pixel waiting, the sequencer holds
//   the next pixel in its pipeline; nothing is dropped. s_ready is high only
//   when no tick is in progress.
//   Reset (aresetn, synchronous): layers read as zero through valid bits, the
//   display until the first tick ends; counters and offsets clear, registers take
//   their defaults. No clearing pass is needed; the block is ready the cycle after reset.
//   The user writes configuration over the APB port while the block is idle; the block does not enforce it.
module led_layer_rotate_mix_engine #(
    parameter int NUM_LEDS = 60
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [1:0]                 s_layer,
    input  logic [5:0]                 s_index,
    input  logic [15:0]                s_color,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [23:0]                m_grb_word,
    output logic [5:0]                 m_pixel_index,
    output logic                       m_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import lrm_pkg::*;

    localparam logic [6:0] LED_CNT  = 7'(NUM_LEDS);
    localparam logic [5:0] LAST_PIX = 6'(NUM_LEDS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RDA  = 2'd1;
    localparam logic [1:0] ST_RDB  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    cfg_t cfg;

    logic [1:0]              state_reg, state_next;
    logic [5:0]              pix_cnt_reg, pix_cnt_next;
    logic [5:0]              work_idx_reg;
    logic                    pend_reg, pend_next;
    logic                    flash_reg, flash_next;
    logic                    built_reg;
    logic [15:0]             frame_pos_reg, frame_pos_next;
    logic [LAYERS-1:0][15:0] rot_cnt_reg, rot_cnt_next;
    logic [LAYERS-1:0][5:0]  ofs_reg, ofs_next;

    logic [15:0]             lyr_mem [LYR_DEPTH];
    logic [LYR_DEPTH-1:0]    lyr_vld_reg;
    logic [15:0]             disp_mem [RING];
    logic [15:0]             rdata_a_reg, rdata_b_reg, disp_rdata_reg;
    logic                    vld_a_reg, vld_b_reg;
    logic [15:0]             s01_reg, pix_reg;

    logic                    m_valid_reg;
    logic [23:0]             m_grb_reg;
    logic [5:0]              m_idx_reg;
    logic                    m_last_reg;

    logic                    tick_acc, load_acc, out_free, step_rda, emit;
    logic                    ren_a, ren_b, lyr_we;
    logic [LYR_AW-1:0]       addr_a, addr_b, lyr_waddr;
    logic [5:0]              load_ofs;
    logic [15:0]             mix_color, emit_color;
    logic [16:0]             pos_inc;

    // Logical strip position to physical ring slot
    function automatic logic [5:0] phys(input logic [5:0] ofs, input logic [5:0] idx);
        logic [6:0] sum;
        sum = {1'b0, idx} + {1'b0, ofs};
        if (sum >= LED_CNT) begin
            sum = sum - LED_CNT;
        end
        return sum[5:0];
    endfunction

    lrm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Handshake and sequencing strobes
    assign s_ready  = (state_reg == ST_IDLE);
    assign tick_acc = s_valid && s_ready && s_op;
    assign load_acc = s_valid && s_ready && !s_op;
    assign out_free = !m_valid_reg || m_ready;
    assign step_rda = (state_reg == ST_RDA) && (!pend_reg || out_free);
    assign emit     = (step_rda && pend_reg) || ((state_reg == ST_FIN) && out_free);

    // Layer RAM addressing
    always_comb begin
        case (s_layer)
            2'd0:    load_ofs = ofs_reg[0];
            2'd1:    load_ofs = ofs_reg[1];
            2'd2:    load_ofs = ofs_reg[2];
            default: load_ofs = 6'd0;
        endcase
    end

    assign lyr_we    = load_acc && (s_layer != 2'd3) && ({1'b0, s_index} < LED_CNT);
    assign lyr_waddr = {s_layer, phys(load_ofs, s_index)};
    assign ren_a     = step_rda || (state_reg == ST_RDB);
    assign ren_b     = step_rda;
    assign addr_a    = (state_reg == ST_RDB) ? {2'd2, phys(ofs_reg[2], pix_cnt_reg)}
                                             : {2'd0, phys(ofs_reg[0], pix_cnt_reg)};
    assign addr_b    = {2'd1, phys(ofs_reg[1], pix_cnt_reg)};

    // Layer RAM: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (lyr_we) begin
            lyr_mem[lyr_waddr] <= s_color;
        end
        if (ren_a) begin
            rdata_a_reg <= lyr_mem[addr_a];
        end
        if (ren_b) begin
            rdata_b_reg <= lyr_mem[addr_b];
        end
    end

    // Layer valid bits and their read-side copies
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lyr_vld_reg <= '0;
        end else if (lyr_we) begin
            lyr_vld_reg[lyr_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ren_a) begin
            vld_a_reg <= lyr_vld_reg[addr_a];
        end
        if (ren_b) begin
            vld_b_reg <= lyr_vld_reg[addr_b];
        end
    end

    // Final mix of the pending pixel
    assign mix_color  = sat_add565(s01_reg, vld_a_reg ? rdata_a_reg : 16'd0);
    assign emit_color = flash_reg ? WHITE_565 : pix_reg;

    // Display buffer: write back mixed pixel, read the one to show next
    always_ff @(posedge aclk) begin
        if (emit) begin
            disp_mem[work_idx_reg] <= mix_color;
        end
        if (step_rda) begin
            disp_rdata_reg <= disp_mem[pix_cnt_reg];
        end
    end

    // Pixel pipeline between the two read phases
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RDB) begin
            s01_reg      <= sat_add565(vld_a_reg ? rdata_a_reg : 16'd0,
                                       vld_b_reg ? rdata_b_reg : 16'd0);
            pix_reg      <= built_reg ? disp_rdata_reg : 16'd0;
            work_idx_reg <= pix_cnt_reg;
        end
    end

    // Frame position, flash decision, rotation counters and ring offsets
    assign pos_inc = {1'b0, frame_pos_reg} + 17'd1;

    always_comb begin
        frame_pos_next = frame_pos_reg;
        flash_next     = flash_reg;
        rot_cnt_next   = rot_cnt_reg;
        ofs_next       = ofs_reg;
        if (tick_acc) begin
            frame_pos_next = (pos_inc >= {1'b0, cfg.flash_period}) ? 16'd0 : pos_inc[15:0];
            flash_next = cfg.flash_enable &&
                         (((frame_pos_next > WIN1_LO) && (frame_pos_next < WIN1_HI)) ||
                          ((frame_pos_next > WIN2_LO) && (frame_pos_next < WIN2_HI)));
            for (int n = 0; n < LAYERS; n++) begin
                if (({1'b0, rot_cnt_reg[n]} + 17'd1) >= {1'b0, cfg.layer_period[n]}) begin
                    rot_cnt_next[n] = 16'd0;
                    if (cfg.direction_mask[n]) begin
                        ofs_next[n] = (ofs_reg[n] == 6'd0) ? LAST_PIX : ofs_reg[n] - 6'd1;
                    end else begin
                        ofs_next[n] = (ofs_reg[n] == LAST_PIX) ? 6'd0 : ofs_reg[n] + 6'd1;
                    end
                end else begin
                    rot_cnt_next[n] = rot_cnt_reg[n] + 16'd1;
                end
            end
        end
    end

    // Tick sequencer
    always_comb begin
        state_next   = state_reg;
        pix_cnt_next = pix_cnt_reg;
        pend_next    = pend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_acc) begin
                    state_next   = ST_RDA;
                    pix_cnt_next = 6'd0;
                    pend_next    = 1'b0;
                end
            end
            ST_RDA: begin
                if (step_rda) begin
                    state_next = ST_RDB;
                    pend_next  = 1'b0;
                end
            end
            ST_RDB: begin
                pend_next = 1'b1;
                if (pix_cnt_reg == LAST_PIX) begin
                    state_next = ST_FIN;
                end else begin
                    state_next   = ST_RDA;
                    pix_cnt_next = pix_cnt_reg + 6'd1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pix_cnt_reg   <= 6'd0;
            pend_reg      <= 1'b0;
            flash_reg     <= 1'b0;
            built_reg     <= 1'b0;
            frame_pos_reg <= 16'd0;
            rot_cnt_reg   <= '0;
            ofs_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            pix_cnt_reg   <= pix_cnt_next;
            pend_reg      <= pend_next;
            flash_reg     <= flash_next;
            frame_pos_reg <= frame_pos_next;
            rot_cnt_reg   <= rot_cnt_next;
            ofs_reg       <= ofs_next;
            if ((state_reg == ST_FIN) && out_free) begin
                built_reg <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_grb_reg  <= expand_grb(emit_color);
            m_idx_reg  <= work_idx_reg;
            m_last_reg <= (work_idx_reg == LAST_PIX);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_grb_word    = m_grb_reg;
    assign m_pixel_index = m_idx_reg;
    assign m_last        = m_last_reg;

`ifndef SYNTHESIS
    // Ring offsets always name a slot inside the strip
    a_ofs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, ofs_reg[0]} < LED_CNT) && ({1'b0, ofs_reg[1]} < LED_CNT) &&
        ({1'b0, ofs_reg[2]} < LED_CNT))
        else $error("ring offset out of range");

    // The final pixel of a frame leaves only from the closing state
    a_last_in_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (work_idx_reg == LAST_PIX)) |-> (state_reg == ST_FIN))
        else $error("last pixel emitted outside closing state");

    // A stalled pending pixel keeps its slot and position
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RDA) && pend_reg && !out_free) |=>
        ((state_reg == ST_RDA) && pend_reg && $stable(work_idx_reg)))
        else $error("pending pixel lost during stall");

    // The closing state always has a pixel to deliver
    a_fin_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> pend_reg)
        else $error("closing state without pending pixel");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench of the LED layer mix engine: layer loads and frame ticks checked against a predictor.
module tb;
    import lrm_pkg::*;

    localparam int   NUM_LEDS      = 60;
    localparam int   SETTLE_CYCLES = 2 * NUM_LEDS + 10;
    localparam int   MAX_SHOWN     = 10;
    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_TICK       = 1'b1;

    typedef struct packed {
        logic        op;
        logic [1:0]  layer;
        logic [5:0]  index;
        logic [15:0] color;
    } strip_item_t;

    typedef struct packed {
        logic [23:0] grb_word;
        logic [5:0]  pixel_index;
        logic        last;
    } pixel_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op    = 1'b0;
    logic [1:0]  s_layer = '0;
    logic [5:0]  s_index = '0;
    logic [15:0] s_color = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_grb_word;
    logic [5:0]  m_pixel_index;
    logic        m_last;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    led_layer_rotate_mix_engine #(
        .NUM_LEDS(NUM_LEDS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_layer       (s_layer),
        .s_index       (s_index),
        .s_color       (s_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_grb_word    (m_grb_word),
        .m_pixel_index (m_pixel_index),
        .m_last        (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state: layer rings, display buffer, counters and register copy
    logic [15:0] ring_mem [LAYERS][RING];
    logic [15:0] shown_mem [RING];
    logic [15:0] rot_count [LAYERS];
    logic [15:0] frame_pos;
    cfg_t        model_cfg;

    strip_item_t item_backlog[$];
    pixel_t      due_pixels[$];
    int          mismatches = 0;
    int          rx_count   = 0;
    int          cyc        = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    // Random idling on either side, except for one calm stretch
    function automatic logic take_break();
        if (cyc >= 4000 && cyc < 10000)
            return 1'b0;
        return $urandom_range(99) < 32;
    endfunction

    function automatic logic [23:0] to_grb(input logic [15:0] c);
        logic [23:0] w;
        w        = '0;
        w[23:18] = c[10:5];
        w[15:11] = c[15:11];
        w[7:3]   = c[4:0];
        return w;
    endfunction

    function automatic logic [15:0] mix565(input logic [15:0] x, input logic [15:0] y);
        int r;
        int g;
        int b;
        r = int'(x[15:11]) + int'(y[15:11]);
        g = int'(x[10:5]) + int'(y[10:5]);
        b = int'(x[4:0]) + int'(y[4:0]);
        if (r > 31) r = 31;
        if (g > 63) g = 63;
        if (b > 31) b = 31;
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    // One frame tick: stream the display, rotate due layers, rebuild the display
    task automatic advance_frame();
        logic [16:0] pos;
        logic [16:0] cnt;
        logic        flash;
        logic [15:0] keep;
        pixel_t      px;
        pos = {1'b0, frame_pos} + 17'd1;
        if (pos >= {1'b0, model_cfg.flash_period})
            pos = '0;
        frame_pos = pos[15:0];
        flash = model_cfg.flash_enable &&
                ((pos > WIN1_LO && pos < WIN1_HI) || (pos > WIN2_LO && pos < WIN2_HI));

        for (int i = 0; i < NUM_LEDS; i++) begin
            px.grb_word    = to_grb(flash ? WHITE_565 : shown_mem[i]);
            px.pixel_index = i[5:0];
            px.last        = (i == NUM_LEDS - 1);
            due_pixels.push_back(px);
        end

        for (int n = 0; n < LAYERS; n++) begin
            cnt = {1'b0, rot_count[n]} + 17'd1;
            if (cnt >= {1'b0, model_cfg.layer_period[n]}) begin
                cnt = '0;
                if (model_cfg.direction_mask[n]) begin
                    keep = ring_mem[n][NUM_LEDS-1];
                    for (int i = NUM_LEDS - 1; i > 0; i--)
                        ring_mem[n][i] = ring_mem[n][i-1];
                    ring_mem[n][0] = keep;
                end else begin
                    keep = ring_mem[n][0];
                    for (int i = 0; i < NUM_LEDS - 1; i++)
                        ring_mem[n][i] = ring_mem[n][i+1];
                    ring_mem[n][NUM_LEDS-1] = keep;
                end
            end
            rot_count[n] = cnt[15:0];
        end

        for (int i = 0; i < NUM_LEDS; i++)
            shown_mem[i] = mix565(mix565(ring_mem[0][i], ring_mem[1][i]), ring_mem[2][i]);
    endtask

    task automatic apply_item(input strip_item_t it);
        if (it.op == OP_TICK)
            advance_frame();
        else if (it.layer < LAYERS && it.index < NUM_LEDS)
            ring_mem[it.layer][it.index] = it.color;
    endtask

    // Input driver: present backlog items, hold each until its transfer
    always @(posedge aclk) begin
        strip_item_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                apply_item({s_op, s_layer, s_index, s_color});
            if (!s_valid || s_ready) begin
                if (item_backlog.size() != 0 && !take_break()) begin
                    cur = item_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_op    <= cur.op;
                    s_layer <= cur.layer;
                    s_index <= cur.index;
                    s_color <= cur.color;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor and receiver backpressure
    int   hold_left     = 0;
    logic pressure_done = 1'b0;

    // One long hold-off so the block backs up into its input, counted in cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!pressure_done && rx_count >= 1500) begin
            pressure_done <= 1'b1;
            hold_left     <= 800;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_grb_word, m_pixel_index, m_last};
                rx_count <= rx_count + 1;
                if (due_pixels.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_SHOWN)
                        $display("tb: unexpected pixel: grb %h index %0d last %b",
                                 got.grb_word, got.pixel_index, got.last);
                end else begin
                    want = due_pixels.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        // grb / index / last
                        if (mismatches <= MAX_SHOWN)
                            $display("tb: mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     want.grb_word, want.pixel_index, want.last,
                                     got.grb_word, got.pixel_index, got.last);
                    end
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= !take_break();
            end
        end
    end

    // APB write: setup then access; register lands on the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_L1_PERIOD: model_cfg.layer_period[0] = val[15:0];
            REG_L2_PERIOD: model_cfg.layer_period[1] = val[15:0];
            REG_L3_PERIOD: model_cfg.layer_period[2] = val[15:0];
            REG_DIR_MASK:  model_cfg.direction_mask  = val[2:0];
            REG_FL_PERIOD: model_cfg.flash_period    = val[15:0];
            REG_FL_ENABLE: model_cfg.flash_enable    = val[0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [15:0] p1, input logic [15:0] p2, input logic [15:0] p3,
                           input logic [2:0] dir, input logic [15:0] fper, input logic fen);
        write_reg(REG_L1_PERIOD, {16'h0, p1});
        write_reg(REG_L2_PERIOD, {16'h0, p2});
        write_reg(REG_L3_PERIOD, {16'h0, p3});
        write_reg(REG_DIR_MASK, {29'h0, dir});
        write_reg(REG_FL_PERIOD, {16'h0, fper});
        write_reg(REG_FL_ENABLE, {31'h0, fen});
    endtask

    task automatic add_item(input logic op, input logic [1:0] layer, input logic [5:0] index,
                            input logic [15:0] color);
        strip_item_t it;
        it.op    = op;
        it.layer = layer;
        it.index = index;
        it.color = color;
        item_backlog.push_back(it);
    endtask

    // Wait until every item is taken and every pixel seen, then let the block settle
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (item_backlog.size() != 0 || s_valid || due_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly in-range loads and ticks, some loads to a missing layer or past the strip
    function automatic strip_item_t random_item();
        strip_item_t it;
        it.op    = ($urandom_range(99) < 60) ? OP_TICK : OP_LOAD;
        it.layer = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
        it.index = ($urandom_range(15) == 0) ? 6'($urandom_range(63, NUM_LEDS))
                                             : 6'($urandom_range(NUM_LEDS - 1));
        case ($urandom_range(7))
            0:       it.color = 16'hFFFF;
            1:       it.color = 16'h0000;
            default: it.color = 16'($urandom);
        endcase
        return it;
    endfunction

    task automatic run_random(input int count);
        repeat (count) item_backlog.push_back(random_item());
        wait_drained();
    endtask

    // Run timeout
    initial begin
        #7_200_000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        foreach (ring_mem[n, i]) ring_mem[n][i] = '0;
        foreach (shown_mem[i]) shown_mem[i] = '0;
        foreach (rot_count[n]) rot_count[n] = '0;
        frame_pos = '0;
        model_cfg.layer_period[0] = RST_L1_PERIOD;
        model_cfg.layer_period[1] = RST_L2_PERIOD;
        model_cfg.layer_period[2] = RST_L3_PERIOD;
        model_cfg.direction_mask  = RST_DIR_MASK;
        model_cfg.flash_period    = RST_FL_PERIOD;
        model_cfg.flash_enable    = RST_FL_ENABLE;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty display, saturating sums, color extremes, ignored loads
        add_item(OP_TICK, 2'd0, 6'd0, 16'h0000);
        add_item(OP_LOAD, 2'd0, 6'd0, 16'hFFFF);
        add_item(OP_LOAD, 2'd1, 6'd0, 16'hFFFF);
        add_item(OP_LOAD, 2'd2, 6'd0, 16'h0841);
        add_item(OP_LOAD, 2'd0, 6'd59, 16'hF800);
        add_item(OP_LOAD, 2'd1, 6'd59, 16'h07E0);
        add_item(OP_LOAD, 2'd2, 6'd59, 16'h001F);
        add_item(OP_LOAD, 2'd0, 6'd63, 16'h1234);
        add_item(OP_LOAD, 2'd3, 6'd5, 16'hFFFF);
        add_item(OP_LOAD, 2'd3, 6'd63, 16'hFFFF);
        add_item(OP_LOAD, 2'd0, 6'd60, 16'hABCD);
        add_item(OP_LOAD, 2'd1, 6'd30, 16'hAAAA);
        add_item(OP_LOAD, 2'd2, 6'd30, 16'h5555);
        add_item(OP_LOAD, 2'd0, 6'd30, 16'h0000);
        add_item(OP_TICK, 2'd3, 6'd63, 16'hFFFF);
        add_item(OP_TICK, 2'd1, 6'd17, 16'h5A5A);
        add_item(OP_LOAD, 2'd2, 6'd1, 16'hFFFF);
        add_item(OP_TICK, 2'd0, 6'd0, 16'h0000);
        add_item(OP_TICK, 2'd2, 6'd42, 16'hC3C3);
        wait_drained();

        // Register settings; flash period stays large early so the windows are reached
        set_all(16'd1, 16'd1, 16'd1, 3'd7, 16'd65535, 1'b1);
        run_random(66);
        set_all(16'd65535, 16'd0, 16'd3, 3'd0, 16'd300, 1'b1);
        run_random(66);
        set_all(16'($urandom_range(65535, 1)), 16'($urandom_range(20, 2)), 16'd0, 3'd5,
                16'd9997, 1'b1);
        run_random(66);
        set_all(16'd2, 16'd5, 16'd7, 3'd2, 16'd65535, 1'b1);
        run_random(66);
        set_all(16'd0, 16'd0, 16'd0, 3'd3, 16'd0, 1'b1);
        run_random(66);
        set_all(16'd1, 16'd2, 16'd3, 3'd6, 16'd1, 1'b0);
        run_random(66);

        if (due_pixels.size() != 0)
            mismatches = mismatches + 1;
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
